/* rtl/deque_with_search_remove_top_assert.svh */
// Assertion macros shared by the deque controller and datapath.
`ifndef DEQUE_WITH_SEARCH_REMOVE_TOP_ASSERT_SVH
`define DEQUE_WITH_SEARCH_REMOVE_TOP_ASSERT_SVH

// Implication checked in the same cycle as the antecedent.
`define DQSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent.
`define DQSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/dqsr_pkg.sv */
// Package with operation codes, status codes, state type and control structs for the deque.
package dqsr_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned OP_W    = 3;
	localparam int unsigned ST_W    = 2;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_CONTAINS   = 3'd4;
	localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;
	localparam logic [OP_W-1:0] OP_PEEK       = 3'd6;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SHIFT,
		S_RD_FRONT,
		S_RD_BACK,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic scan_step;
		logic shift_step;
		logic shift_end;
		logic rd_front;
		logic rd_back;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op_search;
		logic op_remove;
		logic count_zero;
		logic match;
		logic scan_last;
		logic shift_more;
	} sts_t;

endpackage

/* rtl/dqsr_ctrl.sv */
// Controller state machine that sequences each deque request.
`include "deque_with_search_remove_top_assert.svh"

module dqsr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  dqsr_pkg::sts_t sts,
	output dqsr_pkg::cmd_t cmd
);

	dqsr_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != dqsr_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dqsr_pkg::S_IDLE: begin
				if (in_valid) state_d = dqsr_pkg::S_EXEC;
			end
			dqsr_pkg::S_EXEC: begin
				if (sts.op_search && !sts.count_zero) state_d = dqsr_pkg::S_SCAN;
				else state_d = dqsr_pkg::S_RD_FRONT;
			end
			dqsr_pkg::S_SCAN: begin
				priority if (sts.match) begin
					state_d = sts.op_remove ? dqsr_pkg::S_SHIFT : dqsr_pkg::S_RD_FRONT;
				end else if (sts.scan_last) begin
					state_d = dqsr_pkg::S_RD_FRONT;
				end else begin
					state_d = dqsr_pkg::S_SCAN;
				end
			end
			dqsr_pkg::S_SHIFT: begin
				if (!sts.shift_more) state_d = dqsr_pkg::S_RD_FRONT;
			end
			dqsr_pkg::S_RD_FRONT: state_d = dqsr_pkg::S_RD_BACK;
			dqsr_pkg::S_RD_BACK:  state_d = dqsr_pkg::S_DONE;
			dqsr_pkg::S_DONE: begin
				if (out_free) state_d = dqsr_pkg::S_IDLE;
			end
			default: state_d = dqsr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == dqsr_pkg::S_IDLE) && in_valid;
		cmd.exec       = (state_q == dqsr_pkg::S_EXEC);
		cmd.scan_step  = (state_q == dqsr_pkg::S_SCAN);
		cmd.shift_step = (state_q == dqsr_pkg::S_SHIFT) && sts.shift_more;
		cmd.shift_end  = (state_q == dqsr_pkg::S_SHIFT) && !sts.shift_more;
		cmd.rd_front   = (state_q == dqsr_pkg::S_RD_FRONT);
		cmd.rd_back    = (state_q == dqsr_pkg::S_RD_BACK);
		cmd.out_load   = (state_q == dqsr_pkg::S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dqsr_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.out_load || (out_valid_q && out_stall);
		end
	end

	`DQSR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"accepted a transaction but did not go busy")
	`DQSR_ASSERT_NOW(a_no_overwrite, out_valid_q && out_stall, !cmd.out_load,
		"result overwritten while stalled")
	`DQSR_ASSERT_NOW(a_scan_nonempty, state_q == dqsr_pkg::S_SCAN, !sts.count_zero,
		"search walk on an empty queue")

endmodule

/* rtl/dqsr_dpath.sv */
// Datapath of the deque: entry memory, head and count registers, search walk and result register.
`include "deque_with_search_remove_top_assert.svh"

module dqsr_dpath #(
	parameter int unsigned DEPTH = 16,
	localparam int unsigned IdxW = $clog2(DEPTH),
	localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dqsr_pkg::cmd_t                        cmd,
	output dqsr_pkg::sts_t                        sts,
	input  logic [dqsr_pkg::OP_W-1:0]             op,
	input  logic signed [dqsr_pkg::VALUE_W-1:0]   data_value,
	output logic [dqsr_pkg::ST_W-1:0]             status,
	output logic                                  found,
	output logic signed [dqsr_pkg::VALUE_W-1:0]   front_value,
	output logic signed [dqsr_pkg::VALUE_W-1:0]   back_value,
	output logic [CntW-1:0]                       entry_count,
	output logic                                  is_empty
);

	logic [dqsr_pkg::VALUE_W-1:0] mem [DEPTH];
	logic [dqsr_pkg::VALUE_W-1:0] rd_data_q;
	logic [dqsr_pkg::VALUE_W-1:0] value_q;
	logic [dqsr_pkg::VALUE_W-1:0] front_q;
	logic [dqsr_pkg::OP_W-1:0]    op_q;
	logic [dqsr_pkg::ST_W-1:0]    status_q;
	logic                         found_q;
	logic [IdxW-1:0]              head_q;
	logic [CntW-1:0]              count_q;
	logic [CntW-1:0]              scan_q;

	logic                         rd_en, wr_en;
	logic [IdxW-1:0]              rd_addr, wr_addr;
	logic [dqsr_pkg::VALUE_W-1:0] wr_data;
	logic [IdxW-1:0]              head_dec, head_inc;
	logic                         full, empty;
	logic [CntW-1:0]              back_pos;
	logic [CntW:0]                scan_next;

	// Physical slot of a position counted from the front; the sum never reaches twice DEPTH.
	function automatic logic [IdxW-1:0] slot_of(input logic [IdxW-1:0] head,
	                                            input logic [CntW-1:0] pos);
		logic [CntW:0] sum;
		sum = (CntW + 1)'(head) + (CntW + 1)'(pos);
		if (sum >= (CntW + 1)'(DEPTH)) sum = sum - (CntW + 1)'(DEPTH);
		return sum[IdxW-1:0];
	endfunction

	assign full      = (count_q == CntW'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_dec  = (head_q == '0) ? IdxW'(DEPTH - 1) : head_q - IdxW'(1);
	assign head_inc  = (head_q == IdxW'(DEPTH - 1)) ? '0 : head_q + IdxW'(1);
	assign back_pos  = empty ? '0 : count_q - CntW'(1);
	assign scan_next = (CntW + 1)'(scan_q) + (CntW + 1)'(1);

	assign sts.op_search  = (op_q == dqsr_pkg::OP_CONTAINS) || (op_q == dqsr_pkg::OP_REMOVE);
	assign sts.op_remove  = (op_q == dqsr_pkg::OP_REMOVE);
	assign sts.count_zero = empty;
	assign sts.match      = (rd_data_q == value_q);
	assign sts.scan_last  = (scan_next == (CntW + 1)'(count_q));
	assign sts.shift_more = (scan_next < (CntW + 1)'(count_q));

	// Read port: the walk reads one position ahead so a compare or a move completes every cycle.
	always_comb begin
		rd_en   = cmd.exec || cmd.scan_step || cmd.shift_step || cmd.rd_front || cmd.rd_back;
		rd_addr = head_q;
		priority if (cmd.scan_step) begin
			rd_addr = slot_of(head_q, scan_q + CntW'(1));
		end else if (cmd.shift_step) begin
			rd_addr = slot_of(head_q, scan_q + CntW'(2));
		end else if (cmd.rd_back) begin
			rd_addr = slot_of(head_q, back_pos);
		end else begin
			rd_addr = head_q;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = head_dec;
		wr_data = value_q;
		priority if (cmd.shift_step) begin
			wr_en   = 1'b1;
			wr_addr = slot_of(head_q, scan_q);
			wr_data = rd_data_q;
		end else if (cmd.exec && !full && (op_q == dqsr_pkg::OP_PUSH_FRONT)) begin
			wr_en   = 1'b1;
			wr_addr = head_dec;
		end else if (cmd.exec && !full && (op_q == dqsr_pkg::OP_PUSH_BACK)) begin
			wr_en   = 1'b1;
			wr_addr = slot_of(head_q, count_q);
		end else begin
			wr_en   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			unique case (op_q)
				dqsr_pkg::OP_PUSH_FRONT: begin
					if (!full) begin
						head_q  <= head_dec;
						count_q <= count_q + CntW'(1);
					end
				end
				dqsr_pkg::OP_PUSH_BACK: begin
					if (!full) count_q <= count_q + CntW'(1);
				end
				dqsr_pkg::OP_POP_FRONT: begin
					if (!empty) begin
						head_q  <= head_inc;
						count_q <= count_q - CntW'(1);
					end
				end
				dqsr_pkg::OP_POP_BACK: begin
					if (!empty) count_q <= count_q - CntW'(1);
				end
				default: ;
			endcase
		end else if (cmd.shift_end) begin
			count_q <= count_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			value_q <= data_value;
		end
		if (cmd.exec) begin
			found_q <= 1'b0;
			scan_q  <= '0;
			unique case (op_q)
				dqsr_pkg::OP_PUSH_FRONT, dqsr_pkg::OP_PUSH_BACK: begin
					status_q <= full ? dqsr_pkg::ST_FULL : dqsr_pkg::ST_OK;
				end
				dqsr_pkg::OP_POP_FRONT, dqsr_pkg::OP_POP_BACK, dqsr_pkg::OP_PEEK: begin
					status_q <= empty ? dqsr_pkg::ST_EMPTY : dqsr_pkg::ST_OK;
				end
				default: status_q <= dqsr_pkg::ST_OK;
			endcase
		end
		if (cmd.scan_step) begin
			if (sts.match) found_q <= 1'b1;
			else scan_q <= scan_q + CntW'(1);
		end
		if (cmd.shift_step) scan_q <= scan_q + CntW'(1);
		if (cmd.rd_back) front_q <= rd_data_q;
		if (cmd.out_load) begin
			status      <= status_q;
			found       <= found_q;
			front_value <= empty ? '0 : front_q;
			back_value  <= empty ? '0 : rd_data_q;
			entry_count <= count_q;
			is_empty    <= empty;
		end
	end

	`DQSR_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(DEPTH), "entry count beyond depth")
	`DQSR_ASSERT_NOW(a_head_bound, 1'b1, (CntW + 1)'(head_q) < (CntW + 1)'(DEPTH),
		"head index out of range")
	`DQSR_ASSERT_NEXT(a_empty_flag, cmd.out_load, is_empty == (entry_count == '0),
		"empty flag disagrees with count")

endmodule

/* rtl/deque_with_search_remove_top.sv */
// Top level of the deque with search and remove: the controller joined to the datapath.
// Push, pop, peek and the unused code pass through EXEC, RD_FRONT, RD_BACK and DONE before out_valid rises.
// Contains walks the entries in S_SCAN, comparing each in turn until a match or the last entry;
// on a match, remove then moves each later entry up in S_SHIFT and drops the count at its end.
// One request is worked at a time; the next is taken once the result sits in the output register.
// Reset clears the controller, head index and count; memory contents are not cleared.
module deque_with_search_remove_top #(
	parameter int unsigned DEPTH = 16,
	localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [dqsr_pkg::OP_W-1:0]           op,
	input  logic signed [dqsr_pkg::VALUE_W-1:0] data_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dqsr_pkg::ST_W-1:0]           status,
	output logic                                found,
	output logic signed [dqsr_pkg::VALUE_W-1:0] front_value,
	output logic signed [dqsr_pkg::VALUE_W-1:0] back_value,
	output logic [CntW-1:0]                     entry_count,
	output logic                                is_empty
);

	dqsr_pkg::cmd_t cmd;
	dqsr_pkg::sts_t sts;

	dqsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dqsr_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.data_value  (data_value),
		.status      (status),
		.found       (found),
		.front_value (front_value),
		.back_value  (back_value),
		.entry_count (entry_count),
		.is_empty    (is_empty)
	);

endmodule
